### rtl/core/itba_pkg.sv
package itba_pkg;

   localparam int DIV_STEP_BITS = 8;
   localparam int DIGIT_W = 4;
   localparam int CHAR_W = 7;
   localparam int RADIX_W = 5;
   localparam int LIMIT_W = 7;
   localparam int CSR_DATA_W = 7;
   localparam int MAX_BUFFER = 64;

   localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_OCTAL = 5'd8;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd16;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

   localparam logic [CHAR_W-1:0] CHAR_NUL = 7'h00;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_X = 7'h78;

   localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
      7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
      7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
   };

   typedef enum logic [0:0] {
      CSR_RADIX        = 1'b0,
      CSR_BUFFER_LIMIT = 1'b1
   } itba_csr_index_type;

   typedef struct packed {
      logic load;
      logic next;
   } itba_div_ctrl_type;

   typedef struct packed {
      logic               done;
      logic               quotient_zero;
      logic [DIGIT_W-1:0] remainder;
   } itba_div_status_type;

   typedef struct packed {
      logic push;
      logic pop;
   } itba_stack_ctrl_type;

endpackage

### rtl/core/itba_div_unit.sv
module itba_div_unit import itba_pkg::*; #(
   parameter int WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  itba_div_ctrl_type   ctrl,
   input  logic [WIDTH-1:0]    dividend,
   input  logic [RADIX_W-1:0]  divisor,
   output itba_div_status_type status
);

   localparam int CHUNKS = WIDTH / DIV_STEP_BITS;
   localparam int CNT_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

   logic [WIDTH-1:0]   quo_ff, quo_in, quo_step;
   logic [DIGIT_W-1:0] rem_ff, rem_in, rem_step;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DIGIT_W:0]   trial;

   // Restoring long division, one quotient bit per step, eight steps per cycle.
   always_comb begin
      rem_step = rem_ff;
      quo_step = quo_ff;
      trial = '0;
      for (int i = 0; i < DIV_STEP_BITS; i++) begin
         trial = {rem_step, quo_step[WIDTH-1]};
         quo_step = {quo_step[WIDTH-2:0], 1'b0};
         if (trial >= divisor) begin
            trial = trial - divisor;
            quo_step[0] = 1'b1;
         end
         rem_step = trial[DIGIT_W-1:0];
      end
   end

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.load) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (ctrl.next) begin
         rem_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = quo_step;
         rem_in = rem_step;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(CHUNKS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.done = done_ff;
   assign status.quotient_zero = (quo_ff == '0);
   assign status.remainder = rem_ff;

endmodule

### rtl/core/itba_digit_stack.sv
module itba_digit_stack import itba_pkg::*; #(
   parameter int DEPTH = 32
) (
   input  logic                clock,
   input  itba_stack_ctrl_type ctrl,
   input  logic [DIGIT_W-1:0]  push_digit,
   output logic [DIGIT_W-1:0]  top_digit
);

   logic [DIGIT_W-1:0] stack_ff [DEPTH];
   logic [DIGIT_W-1:0] stack_in [DEPTH];

   // The newest digit sits at the top, so digits leave most significant first.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         stack_in[i] = stack_ff[i];
      end
      if (ctrl.push) begin
         stack_in[0] = push_digit;
         for (int i = 1; i < DEPTH; i++) begin
            stack_in[i] = stack_ff[i-1];
         end
      end else if (ctrl.pop) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            stack_in[i] = stack_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         stack_ff[i] <= stack_in[i];
      end
   end

   assign top_digit = stack_ff[0];

endmodule

### rtl/core/integer_to_base_ascii_core.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_value
// rsp       out        rsp_valid/rsp_stall  rsp_character, rsp_last, rsp_overflow
// csr       in         csr_write            csr_index, csr_wdata
//
// Each digit is computed in the shared divider, over the value rounded up to whole bytes.
// After the digits, an item passes through a check state and then sends its characters.
// Reset is synchronous and active high and sets radix to 16 and buffer_limit to 64.
// A new item is taken only after the last character of the previous one has been taken,
// and a stalled result holds its character until the stall drops.
module integer_to_base_ascii_core import itba_pkg::*; #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [CHAR_W-1:0]             rsp_character,
   output logic                          rsp_last,
   output logic                          rsp_overflow,
   input  logic                          csr_write,
   input  logic [0:0]                    csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   localparam int CHUNKS = (VALUE_WIDTH + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
   localparam int DIV_W = CHUNKS * DIV_STEP_BITS;
   localparam int NDIG_W = $clog2(VALUE_WIDTH + 1);
   localparam int LEN_W = $clog2(VALUE_WIDTH + 4);
   localparam int CMP_W = LEN_W + 8;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIVIDE = 4'b0010,
      ST_CHECK  = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [RADIX_W-1:0]    radix_ff, radix_in;
   logic [LIMIT_W-1:0]    limit_ff, limit_in;
   logic [RADIX_W-1:0]    base_ff, base_in;
   logic [LIMIT_W:0]      lim_eff_ff, lim_eff_in;
   logic                  neg_ff, neg_in;
   logic [NDIG_W-1:0]     ndig_ff, ndig_in;
   logic [1:0]            head_ff, head_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic                  err_ff, err_in;
   logic [LEN_W-1:0]      pos_ff, pos_in;

   logic [VALUE_WIDTH-1:0] value_u;
   logic [VALUE_WIDTH-1:0] magnitude;
   logic [RADIX_W-1:0]     base_sel;
   logic [LIMIT_W:0]       lim_sel;
   logic [1:0]             prefix_len;
   logic [LEN_W-1:0]       len_calc;
   logic                   req_take;
   logic                   rsp_take;
   logic                   char_last;
   logic [CHAR_W-1:0]      text_char;

   itba_div_ctrl_type      div_ctrl;
   itba_div_status_type    div_status;
   itba_stack_ctrl_type    stack_ctrl;
   logic [DIGIT_W-1:0]     top_digit;

   assign value_u = req_value;
   assign magnitude = value_u[VALUE_WIDTH-1] ? (~value_u + 1'b1) : value_u;

   assign base_sel = (radix_ff < RADIX_MIN) ? RADIX_MIN :
                     (radix_ff > RADIX_MAX) ? RADIX_MAX : radix_ff;
   assign lim_sel = ({1'b0, limit_ff} > (LIMIT_W+1)'(MAX_BUFFER)) ?
                    (LIMIT_W+1)'(MAX_BUFFER) : {1'b0, limit_ff};
   assign prefix_len = (base_ff == RADIX_MAX) ? 2'd2 :
                       (base_ff == RADIX_OCTAL) ? 2'd1 : 2'd0;
   assign len_calc = LEN_W'({1'b0, neg_ff}) + LEN_W'(prefix_len) + LEN_W'(ndig_ff);

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_take = rsp_valid && !rsp_stall;
   assign char_last = (pos_ff == len_ff - 1'b1);

   always_comb begin
      if (pos_ff < LEN_W'(head_ff)) begin
         if (neg_ff && pos_ff == '0) begin
            text_char = CHAR_MINUS;
         end else if (pos_ff == LEN_W'(head_ff) - 1'b1 && base_ff == RADIX_MAX) begin
            text_char = CHAR_X;
         end else begin
            text_char = CHAR_ZERO;
         end
      end else begin
         text_char = DIGIT_CHARS[top_digit];
      end
   end

   assign rsp_character = err_ff ? CHAR_NUL : text_char;
   assign rsp_last = err_ff || char_last;
   assign rsp_overflow = err_ff;

   always_comb begin
      radix_in = radix_ff;
      limit_in = limit_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_RADIX: begin
               radix_in = csr_wdata[RADIX_W-1:0];
            end
            CSR_BUFFER_LIMIT: begin
               limit_in = csr_wdata[LIMIT_W-1:0];
            end
            default: begin
               radix_in = radix_ff;
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      base_in = base_ff;
      lim_eff_in = lim_eff_ff;
      neg_in = neg_ff;
      ndig_in = ndig_ff;
      head_in = head_ff;
      len_in = len_ff;
      err_in = err_ff;
      pos_in = pos_ff;
      div_ctrl = '0;
      stack_ctrl = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               base_in = base_sel;
               lim_eff_in = lim_sel;
               neg_in = value_u[VALUE_WIDTH-1];
               ndig_in = '0;
               div_ctrl.load = 1'b1;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               stack_ctrl.push = 1'b1;
               ndig_in = ndig_ff + 1'b1;
               if (div_status.quotient_zero ||
                   ndig_ff + 1'b1 == NDIG_W'(VALUE_WIDTH)) begin
                  state_in = ST_CHECK;
               end else begin
                  div_ctrl.next = 1'b1;
               end
            end
         end
         ST_CHECK: begin
            head_in = 2'({1'b0, neg_ff}) + prefix_len;
            len_in = len_calc;
            err_in = (CMP_W'(len_calc) + 1'b1) > CMP_W'(lim_eff_ff);
            pos_in = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_take) begin
               if (err_ff || char_last) begin
                  state_in = ST_IDLE;
               end else begin
                  pos_in = pos_ff + 1'b1;
                  stack_ctrl.pop = (pos_ff >= LEN_W'(head_ff));
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      lim_eff_ff <= lim_eff_in;
      neg_ff <= neg_in;
      ndig_ff <= ndig_in;
      head_ff <= head_in;
      len_ff <= len_in;
      err_ff <= err_in;
      pos_ff <= pos_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         radix_ff <= RADIX_RESET;
         limit_ff <= LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         radix_ff <= radix_in;
         limit_ff <= limit_in;
      end
   end

   itba_div_unit #(
      .WIDTH(DIV_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .ctrl(div_ctrl),
      .dividend(DIV_W'(magnitude)),
      .divisor(base_ff),
      .status(div_status)
   );

   itba_digit_stack #(
      .DEPTH(VALUE_WIDTH)
   ) u_stack (
      .clock(clock),
      .ctrl(stack_ctrl),
      .push_digit(div_status.remainder),
      .top_digit(top_digit)
   );

   a_no_result_while_ready: assert property (
      @(posedge clock) disable iff (reset) !req_stall |-> !rsp_valid
   ) else $error("result offered while the block takes a new item");

   a_ready_after_last: assert property (
      @(posedge clock) disable iff (reset) rsp_valid && !rsp_stall && rsp_last |=> !req_stall
   ) else $error("block did not return to ready after the final character");

   a_digit_bound: assert property (
      @(posedge clock) disable iff (reset) stack_ctrl.push |-> ndig_ff < NDIG_W'(VALUE_WIDTH)
   ) else $error("more digits than the value width allows");

   a_item_starts_divide: assert property (
      @(posedge clock) disable iff (reset) req_valid && !req_stall |=> req_stall && !rsp_valid
   ) else $error("accepted item did not start a conversion");

endmodule
